// File: hw/rtl/edge_coverage_hit_map_top_macros.svh
// Assertion macros for the edge coverage hit map RTL, used by the back part.
`ifndef EDGE_COVERAGE_HIT_MAP_TOP_MACROS_SVH
`define EDGE_COVERAGE_HIT_MAP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ECOV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecov assertion failed");

// Next-cycle implication, disabled during reset.
`define ECOV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecov assertion failed");

`endif

// File: hw/rtl/ecov_pkg.sv
// Shared constants for the edge coverage hit map.
package ecov_pkg;

  localparam int ADDR_W  = 64;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 8;
  localparam int OP_W    = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RECORD     = 2'd0;
  localparam logic [OP_W-1:0] OP_READ       = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

  // Register word index (paddr[2])
  localparam logic REG_MAP_ENABLE = 1'b0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

endpackage

// File: hw/rtl/ecov_if.sv
// Valid/ready channel interfaces for the edge coverage hit map.
interface ecov_in_if;
  logic                           valid;
  logic                           ready;
  logic [ecov_pkg::OP_W-1:0]      operation;
  logic [ecov_pkg::ADDR_W-1:0]    block_address;
  logic [ecov_pkg::INDEX_W-1:0]   entry_index;

  modport source (output valid, output operation, output block_address,
                  output entry_index, input ready);
  modport sink   (input valid, input operation, input block_address,
                  input entry_index, output ready);
endinterface

interface ecov_out_if;
  logic                           valid;
  logic                           ready;
  logic [ecov_pkg::INDEX_W-1:0]   edge_index;
  logic [ecov_pkg::COUNT_W-1:0]   hit_count;

  modport source (output valid, output edge_index, output hit_count, input ready);
  modport sink   (input valid, input edge_index, input hit_count, output ready);
endinterface

// File: hw/rtl/ecov_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ecov_queue.sv
// Small FIFO between the front and back parts.
module ecov_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/ecov_front.sv
// Front part: accepts items, folds addresses, forms edge indexes.
module ecov_front #(
  parameter int MAP_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  ecov_in_if.sink                      in,
  input  logic                         clearing,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [ecov_pkg::OP_W+MAP_BITS-1:0] push_data
);

  logic [MAP_BITS-2:0]                       prior_location;
  logic [ecov_pkg::ADDR_W-1:0]               folded;
  logic [MAP_BITS-1:0]                       loc;
  logic [MAP_BITS-1:0]                       edge_idx;
  logic [MAP_BITS+ecov_pkg::INDEX_W-1:0]     entry_ext;
  logic [MAP_BITS-1:0]                       read_idx;
  logic [ecov_pkg::OP_W-1:0]                 op_norm;
  logic [MAP_BITS-1:0]                       idx;
  logic                                      accept;

  assign folded    = in.block_address ^ (in.block_address >> 4);
  assign loc       = folded[MAP_BITS-1:0];
  assign edge_idx  = {1'b0, prior_location} ^ loc;
  assign entry_ext = {{MAP_BITS{1'b0}}, in.entry_index};
  assign read_idx  = entry_ext[MAP_BITS-1:0];

  // Fold the unused code onto a plain read.
  always_comb begin
    unique case (in.operation)
      ecov_pkg::OP_RECORD:     op_norm = ecov_pkg::OP_RECORD;
      ecov_pkg::OP_READ_CLEAR: op_norm = ecov_pkg::OP_READ_CLEAR;
      default:                 op_norm = ecov_pkg::OP_READ;
    endcase
  end

  assign idx        = (op_norm == ecov_pkg::OP_RECORD) ? edge_idx : read_idx;
  assign in.ready   = push_ready && !clearing;
  assign push_valid = in.valid && !clearing;
  assign push_data  = {op_norm, idx};
  assign accept     = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_location <= '0;
    end else if (accept && (op_norm == ecov_pkg::OP_RECORD)) begin
      prior_location <= loc[MAP_BITS-1:1];
    end
  end

endmodule

// File: hw/rtl/ecov_back.sv
// Back part: clears the map after reset, then runs read-modify-write per item.
`include "edge_coverage_hit_map_top_macros.svh"

module ecov_back #(
  parameter int MAP_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                map_enable,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [ecov_pkg::OP_W+MAP_BITS-1:0]  pop_data,
  output logic                                clearing,
  ecov_out_if.source                          out
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [MAP_BITS-1:0]                 clr_addr;
  logic [ecov_pkg::OP_W-1:0]           cur_op;
  logic [MAP_BITS-1:0]                 cur_index;
  logic                                out_valid;
  logic [ecov_pkg::INDEX_W-1:0]        out_edge;
  logic [ecov_pkg::COUNT_W-1:0]        out_count;
  logic                                ram_we;
  logic [MAP_BITS-1:0]                 ram_waddr;
  logic [ecov_pkg::COUNT_W-1:0]        ram_wdata;
  logic [ecov_pkg::COUNT_W-1:0]        ram_rdata;
  logic [ecov_pkg::COUNT_W-1:0]        new_count;
  logic                                upd_we;
  logic [MAP_BITS+ecov_pkg::INDEX_W-1:0] index_ext;

  ecov_ram #(
    .WIDTH (ecov_pkg::COUNT_W),
    .DEPTH (1 << MAP_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pop_data[MAP_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign clearing  = (state == ST_CLEAR);
  // Issue once the output register is empty or empties this cycle.
  assign pop_ready = (state == ST_IDLE) && (!out_valid || out.ready);

  // Update of the entry read in the previous cycle.
  always_comb begin
    new_count = ram_rdata;
    upd_we    = 1'b0;
    unique case (cur_op)
      ecov_pkg::OP_RECORD: begin
        if (map_enable) begin
          upd_we    = 1'b1;
          new_count = (ram_rdata == ecov_pkg::COUNT_MAX) ?
                      ecov_pkg::COUNT_W'(1) : ram_rdata + ecov_pkg::COUNT_W'(1);
        end
      end
      ecov_pkg::OP_READ_CLEAR: begin
        upd_we = 1'b1;
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_DATA) && upd_we;
      ram_waddr = cur_index;
      ram_wdata = (cur_op == ecov_pkg::OP_RECORD) ? new_count : '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == {MAP_BITS{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:  if (pop_valid && pop_ready) state_next = ST_DATA;
      ST_DATA:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  assign index_ext = {{ecov_pkg::INDEX_W{1'b0}}, cur_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + MAP_BITS'(1);
      end
      if (state == ST_DATA) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_op    <= pop_data[ecov_pkg::OP_W+MAP_BITS-1:MAP_BITS];
      cur_index <= pop_data[MAP_BITS-1:0];
    end
    if (state == ST_DATA) begin
      out_edge  <= index_ext[ecov_pkg::INDEX_W-1:0];
      out_count <= new_count;
    end
  end

  assign out.valid      = out_valid;
  assign out.edge_index = out_edge;
  assign out.hit_count  = out_count;

  `ECOV_ASSERT_NOW(a_no_issue_while_clearing, clk, rst, state == ST_CLEAR, !pop_ready)
  `ECOV_ASSERT_NEXT(a_result_follows_update, clk, rst, state == ST_DATA, out_valid)
  `ECOV_ASSERT_NOW(a_count_never_zero, clk, rst, (state == ST_DATA) && map_enable && (cur_op == ecov_pkg::OP_RECORD), ram_we && (ram_wdata != '0))

endmodule

// File: hw/rtl/edge_coverage_hit_map_top.sv
// Top level of the edge coverage hit map: register port, front, queue, back.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-----------------------------------------
//   in      | in  | valid/ready      | operation, block_address, entry_index
//   out     | out | valid/ready      | edge_index, hit_count
//   apb     | in  | psel/penable     | paddr, pwdata, prdata (map_enable at 0)
//
// After reset the back part sweeps the map to zero, one entry per cycle over all
// 2^MAP_BITS entries (65536 at the default), with in.ready low throughout;
// register writes are taken during the sweep.
// Each item then passes through the back part in order, set by the single map RAM
// port pair: ST_IDLE reads the entry, then ST_DATA updates, writes and loads the
// output register, and no new item is taken until ST_IDLE. A two-entry queue lets
// the front take items while the back works or while a result waits on out.ready.
module edge_coverage_hit_map_top #(
  parameter int MAP_BITS    = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  ecov_in_if.sink                       in,
  ecov_out_if.source                    out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecov_pkg::PADDR_W-1:0]  paddr,
  input  logic [ecov_pkg::PDATA_W-1:0]  pwdata,
  output logic [ecov_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int Q_W = ecov_pkg::OP_W + MAP_BITS;

  logic           map_enable;
  logic           clearing;
  logic           push_valid;
  logic           push_ready;
  logic [Q_W-1:0] push_data;
  logic           pop_valid;
  logic           pop_ready;
  logic [Q_W-1:0] pop_data;
  logic           reg_sel;

  // Register port: one word, writes complete in the access phase.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ecov_pkg::REG_MAP_ENABLE);
  assign prdata  = reg_sel ? {{(ecov_pkg::PDATA_W-1){1'b0}}, map_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      map_enable <= pwdata[0];
    end
  end

  // Front: classify and hold the previous location.
  ecov_front #(
    .MAP_BITS (MAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front and back so each can stall on its own.
  ecov_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: map RAM read-modify-write and the output register.
  ecov_back #(
    .MAP_BITS (MAP_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .map_enable (map_enable),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .clearing   (clearing),
    .out        (out)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for the edge coverage hit map: stimulus, prediction, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecov_pkg::*;

  localparam int MAP_BITS    = 16;
  localparam int MAP_ENTRIES = 1 << MAP_BITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 17;
  localparam int POOL_SIZE   = 8;

  // The fourth operation code has no function; it acts as a plain read.
  localparam logic [OP_W-1:0]    OP_UNUSED       = 2'd3;
  localparam logic [PADDR_W-1:0] MAP_ENABLE_ADDR = {REG_MAP_ENABLE, 2'b00};

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [INDEX_W-1:0] index;
  } block_event_t;

  typedef struct packed {
    logic [INDEX_W-1:0] edge_idx;
    logic [COUNT_W-1:0] count;
  } hit_result_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ecov_in_if  event_ch ();
  ecov_out_if hit_ch ();

  edge_coverage_hit_map_top #(
    .MAP_BITS (MAP_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in      (event_ch),
    .out     (hit_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's state, advanced on every accepted transfer.
  logic [COUNT_W-1:0]  shadow_map [MAP_ENTRIES];
  logic [MAP_BITS-2:0] shadow_prior;
  logic                shadow_enable;

  block_event_t pending_events[$];
  block_event_t driven_event;
  hit_result_t  predicted_hits[$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  // While set, neither side inserts idle cycles.
  logic steady;
  int   mismatch_count;
  int   cycle_count;
  // Events taken off the pending queue whose hit has not come back yet.
  int   in_flight;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fold a block address to its map location.
  function automatic logic [MAP_BITS-1:0] fold_address(logic [ADDR_W-1:0] a);
    return a[MAP_BITS-1:0] ^ a[MAP_BITS+3:4];
  endfunction

  // Apply one event to the shadow state and return the hit it must report.
  function automatic hit_result_t apply_event(block_event_t ev);
    logic [MAP_BITS-1:0] loc;
    logic [MAP_BITS-1:0] idx;
    logic [COUNT_W-1:0]  cnt;
    hit_result_t         res;
    if (ev.op == OP_RECORD) begin
      loc = fold_address(ev.addr);
      idx = {1'b0, shadow_prior} ^ loc;
      cnt = shadow_map[idx];
      if (shadow_enable) begin
        // Wrap to one instead of zero so a visited edge never reads as zero.
        cnt = (cnt == COUNT_MAX) ? 8'd1 : cnt + 8'd1;
        shadow_map[idx] = cnt;
      end
      shadow_prior = loc[MAP_BITS-1:1];
    end else begin
      idx = ev.index[MAP_BITS-1:0];
      cnt = shadow_map[idx];
      if (ev.op == OP_READ_CLEAR) begin
        shadow_map[idx] = '0;
      end
    end
    res.edge_idx = idx[INDEX_W-1:0];
    res.count    = cnt;
    return res;
  endfunction

  function automatic block_event_t make_event(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                              logic [INDEX_W-1:0] i);
    block_event_t ev;
    ev.op    = op;
    ev.addr  = a;
    ev.index = i;
    return ev;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [INDEX_W-1:0] random_index();
    return INDEX_W'($urandom());
  endfunction

  // Pick an edge that pool addresses are likely to have touched.
  function automatic logic [INDEX_W-1:0] pool_edge();
    return (fold_address(addr_pool[$urandom_range(0, POOL_SIZE-1)]) >> 1) ^
           fold_address(addr_pool[$urandom_range(0, POOL_SIZE-1)]);
  endfunction

  // Write the enable register over the APB port; only called while idle.
  task automatic write_map_enable(logic value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAP_ENABLE_ADDR;
    pwdata  <= {{(PDATA_W-1){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_enable = value;
  endtask

  // Hold until every queued transfer has gone out and every hit has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_events.size() != 0 || in_flight != 0);
  endtask

  task automatic queue_random_events(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        pending_events.push_back(make_event(OP_RECORD,
                                 addr_pool[$urandom_range(0, POOL_SIZE-1)], '0));
      end else if (roll < 70) begin
        pending_events.push_back(make_event(OP_RECORD, random_address(), random_index()));
      end else if (roll < 85) begin
        pending_events.push_back(make_event(OP_READ, random_address(), pool_edge()));
      end else if (roll < 93) begin
        pending_events.push_back(make_event(OP_READ_CLEAR, random_address(), pool_edge()));
      end else if (roll < 97) begin
        pending_events.push_back(make_event(OP_READ, random_address(), random_index()));
      end else begin
        pending_events.push_back(make_event(OP_UNUSED, random_address(), random_index()));
      end
    end
  endtask

  // Driver: present the next pending event, hold it until the transfer.
  always @(posedge clk) begin
    if (rst) begin
      event_ch.valid <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        predicted_hits.push_back(apply_event(driven_event));
      end
      if (!event_ch.valid || event_ch.ready) begin
        if (pending_events.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          driven_event            = pending_events.pop_front();
          in_flight++;
          event_ch.valid         <= 1'b1;
          event_ch.operation     <= driven_event.op;
          event_ch.block_address <= driven_event.addr;
          event_ch.entry_index   <= driven_event.index;
        end else begin
          event_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each hit transfer against the oldest prediction.
  always @(posedge clk) begin
    hit_result_t want;
    if (rst) begin
      hit_ch.ready <= 1'b0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (predicted_hits.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected hit: edge_index %h hit_count %0d",
                     hit_ch.edge_index, hit_ch.hit_count);
          end
        end else begin
          want = predicted_hits.pop_front();
          in_flight--;
          if (hit_ch.edge_index !== want.edge_idx || hit_ch.hit_count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("hit mismatch: edge_index %h (want %h) hit_count %0d (want %0d)",
                       hit_ch.edge_index, want.edge_idx, hit_ch.hit_count, want.count);
            end
          end
        end
      end
      hit_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: the post-reset sweep plus all traffic fits well inside the limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] hot_addr;
    logic [MAP_BITS-1:0] hot_loc;

    // Drive every input to a known value before the first edge.
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    event_ch.valid         = 1'b0;
    event_ch.operation     = OP_RECORD;
    event_ch.block_address = '0;
    event_ch.entry_index   = '0;
    hit_ch.ready           = 1'b0;
    steady                 = 1'b0;
    mismatch_count         = 0;
    cycle_count            = 0;
    in_flight              = 0;
    shadow_prior           = '0;
    shadow_enable          = 1'b1;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      shadow_map[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = random_address();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The register port works during the clearing sweep; the event channel
    // simply waits for ready.
    write_map_enable(1'b1);

    // Directed: fresh entries, corner addresses (some fold to location zero),
    // the unused operation code, and a read-and-clear round trip.
    pending_events.push_back(make_event(OP_READ, '0, 16'h0000));
    pending_events.push_back(make_event(OP_READ, '1, 16'hffff));
    pending_events.push_back(make_event(OP_UNUSED, '0, 16'h00ff));
    pending_events.push_back(make_event(OP_RECORD, 64'h0, '0));
    pending_events.push_back(make_event(OP_RECORD, 64'h0, '1));
    pending_events.push_back(make_event(OP_RECORD, 64'hffff_ffff_ffff_ffff, '0));
    pending_events.push_back(make_event(OP_RECORD, 64'h8000_0000_0000_0000, '0));
    pending_events.push_back(make_event(OP_READ, '0, 16'h0000));
    pending_events.push_back(make_event(OP_RECORD, 64'h0000_0000_000f_fff0, '0));
    pending_events.push_back(make_event(OP_RECORD, 64'h0000_0000_0000_ffff, '0));
    pending_events.push_back(make_event(OP_READ, '0, 16'hf007));
    pending_events.push_back(make_event(OP_READ_CLEAR, '0, 16'hf007));
    pending_events.push_back(make_event(OP_READ, '0, 16'hf007));
    pending_events.push_back(make_event(OP_RECORD, 64'h0000_0000_0001_0000, '0));
    pending_events.push_back(make_event(OP_READ_CLEAR, '0, 16'h0000));
    pending_events.push_back(make_event(OP_READ, '0, 16'h0000));
    pending_events.push_back(make_event(OP_UNUSED, '1, 16'hffff));
    wait_drained();

    // Counting disabled: records report the stored count and only move history.
    write_map_enable(1'b0);
    pending_events.push_back(make_event(OP_RECORD, 64'h0000_0000_0001_0000, '0));
    pending_events.push_back(make_event(OP_RECORD, 64'h0000_0000_0001_0000, '0));
    pending_events.push_back(make_event(OP_RECORD, 64'h0, '0));
    pending_events.push_back(make_event(OP_READ, '0, 16'h1000));
    pending_events.push_back(make_event(OP_UNUSED, '0, 16'h0800));
    wait_drained();

    // Hot loop: one address back to back drives a single edge past 255, so
    // the counter must skip zero on wrap. Run it without idle cycles.
    write_map_enable(1'b1);
    steady   = 1'b1;
    hot_addr = random_address();
    hot_loc  = fold_address(hot_addr);
    for (int n = 0; n < 300; n++) begin
      pending_events.push_back(make_event(OP_RECORD, hot_addr, '0));
    end
    pending_events.push_back(make_event(OP_READ, '0, (hot_loc >> 1) ^ hot_loc));
    pending_events.push_back(make_event(OP_READ_CLEAR, '0, (hot_loc >> 1) ^ hot_loc));
    pending_events.push_back(make_event(OP_RECORD, hot_addr, '0));
    wait_drained();
    steady = 1'b0;

    // Random traffic, mostly loops over a small address pool so edges repeat.
    queue_random_events(30);
    wait_drained();
    queue_random_events(30);
    wait_drained();

    write_map_enable(1'b0);
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = random_address();
    end
    queue_random_events(35);
    wait_drained();

    write_map_enable(1'b1);
    queue_random_events(35);
    wait_drained();

    // Let any late stray output show up before the verdict.
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && predicted_hits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
